// ===== hw/rtl/log_record_deframer_crc32_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the log record deframer
// Shared concurrent assertion forms, clocked on the rising edge with the
// active-low reset masking every check.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_CRC32_ASSERT_SVH
`define LOG_RECORD_DEFRAMER_CRC32_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== hw/rtl/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Log record deframer package
// Types, codes and the byte-wise CRC-32 update shared by the deframer modules.
// ----------------------------------------------------------------------------
package lrd_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam int          KEEP_LEN_W = 32;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_CRC  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            body_byte;
        logic                  has_byte;
        logic                  partial;
        logic [KEEP_LEN_W-1:0] keep_length;
    } t_out_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/lrd_pipe_reg.sv =====
// ----------------------------------------------------------------------------
// Deframer pipeline register
// One valid/ready register stage that holds a beat and refills in the same
// cycle it is drained, so a stream of beats passes at full rate.
// ----------------------------------------------------------------------------
module lrd_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== hw/rtl/lrd_core.sv =====
// ----------------------------------------------------------------------------
// Deframer parser core
// Holds the record parsing state and turns one registered input beat into at
// most one result beat, updating the CRC one byte per cycle while the result side does not stall.
// ----------------------------------------------------------------------------
module lrd_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    input  lrd_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output lrd_pkg::t_out_item o_res
);

    localparam int KW     = lrd_pkg::KEEP_LEN_W;
    localparam int KEEP_W = (OFFSET_BITS < KW) ? OFFSET_BITS : KW;

    lrd_pkg::t_phase        r_phase, n_phase;
    logic [1:0]             r_hdr_idx, n_hdr_idx;
    logic [31:0]            r_body_rem, n_body_rem;
    logic [31:0]            r_stored, n_stored;
    logic [31:0]            r_crc, n_crc;
    logic [OFFSET_BITS-1:0] r_stream_off, n_stream_off;
    logic [OFFSET_BITS-1:0] r_good_off, n_good_off;
    logic                   r_halted, n_halted;

    logic                   w_produces;
    logic                   w_finish;
    logic                   w_match;
    logic                   w_take;
    logic [31:0]            w_crc_next;
    logic [OFFSET_BITS-1:0] w_off_inc;
    logic [KW-1:0]          w_keep;
    lrd_pkg::t_out_item     w_res;

    assign w_crc_next = lrd_pkg::crc_byte(r_crc, i_item.data_byte);
    assign w_off_inc  = r_stream_off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    assign w_keep     = KW'(r_good_off[KEEP_W-1:0]);

    assign o_item_ready = i_res_ready || !w_produces;
    assign o_res_valid  = i_item_valid && w_produces;
    assign o_res        = w_res;
    assign w_take       = i_item_valid && o_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lrd_pkg::PH_LEN;
            r_hdr_idx    <= 2'd0;
            r_body_rem   <= 32'd0;
            r_stored     <= 32'd0;
            r_crc        <= lrd_pkg::CRC_INIT;
            r_stream_off <= '0;
            r_good_off   <= '0;
            r_halted     <= 1'b0;
        end else if (w_take) begin
            r_phase      <= n_phase;
            r_hdr_idx    <= n_hdr_idx;
            r_body_rem   <= n_body_rem;
            r_stored     <= n_stored;
            r_crc        <= n_crc;
            r_stream_off <= n_stream_off;
            r_good_off   <= n_good_off;
            r_halted     <= n_halted;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_hdr_idx    = r_hdr_idx;
        n_body_rem   = r_body_rem;
        n_stored     = r_stored;
        n_crc        = r_crc;
        n_stream_off = r_stream_off;
        n_good_off   = r_good_off;
        n_halted     = r_halted;
        w_produces   = 1'b0;
        w_finish     = 1'b0;
        w_match      = 1'b0;
        w_res.kind        = lrd_pkg::KIND_BODY;
        w_res.body_byte   = 8'd0;
        w_res.has_byte    = 1'b0;
        w_res.partial     = 1'b0;
        w_res.keep_length = '0;

        if (i_item.end_of_stream) begin
            w_produces        = 1'b1;
            w_res.kind        = lrd_pkg::KIND_END;
            w_res.partial     = !r_halted && ((r_phase != lrd_pkg::PH_LEN) || (r_hdr_idx != 2'd0));
            w_res.keep_length = w_keep;
            n_phase      = lrd_pkg::PH_LEN;
            n_hdr_idx    = 2'd0;
            n_body_rem   = 32'd0;
            n_stored     = 32'd0;
            n_crc        = lrd_pkg::CRC_INIT;
            n_stream_off = '0;
            n_good_off   = '0;
            n_halted     = 1'b0;
        end else if (!r_halted) begin
            n_stream_off = w_off_inc;
            unique case (r_phase)
                lrd_pkg::PH_CRC: begin
                    n_stored[{r_hdr_idx, 3'b000} +: 8] = i_item.data_byte;
                    n_hdr_idx = r_hdr_idx + 2'd1;
                    if (r_hdr_idx == 2'd3) begin
                        if (r_body_rem == 32'd0) begin
                            w_produces = 1'b1;
                            w_finish   = 1'b1;
                            w_match    = (~r_crc == n_stored);
                        end else begin
                            n_phase = lrd_pkg::PH_BODY;
                            n_crc   = lrd_pkg::CRC_INIT;
                        end
                    end
                end
                lrd_pkg::PH_BODY: begin
                    n_crc           = w_crc_next;
                    n_body_rem      = r_body_rem - 32'd1;
                    w_produces      = 1'b1;
                    w_res.has_byte  = 1'b1;
                    w_res.body_byte = i_item.data_byte;
                    if (r_body_rem == 32'd1) begin
                        w_finish = 1'b1;
                        w_match  = (~w_crc_next == r_stored);
                    end
                end
                default: begin
                    n_phase = lrd_pkg::PH_LEN;
                    n_body_rem[{r_hdr_idx, 3'b000} +: 8] = i_item.data_byte;
                    n_hdr_idx = r_hdr_idx + 2'd1;
                    if (r_hdr_idx == 2'd3) begin
                        n_phase  = lrd_pkg::PH_CRC;
                        n_stored = 32'd0;
                    end
                end
            endcase

            if (w_finish) begin
                n_phase    = lrd_pkg::PH_LEN;
                n_hdr_idx  = 2'd0;
                n_body_rem = 32'd0;
                n_crc      = lrd_pkg::CRC_INIT;
                if (w_match) begin
                    n_good_off = w_off_inc;
                    n_stored   = 32'd0;
                    w_res.kind = lrd_pkg::KIND_ACCEPT;
                end else begin
                    n_halted   = 1'b1;
                    w_res.kind = lrd_pkg::KIND_REJECT;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/log_record_deframer_crc32.sv =====
// Path: an accepted beat waits in the input register, the parser core turns it
// into its result and the output register holds that result for the receiver.
// Throughput: one byte per cycle while the receiver keeps i_ready high; the
// byte-wide CRC update sits between the input register and the result register.
// Reset: synchronous, active low, clears the parser state and empties both registers.
// ----------------------------------------------------------------------------
// Log record deframer with CRC-32 check
// Splits a length-prefixed record stream, passes body bytes through, reports
// accepted or rejected records and gives the valid prefix at end of stream.
// ----------------------------------------------------------------------------
`include "log_record_deframer_crc32_assert.svh"

module log_record_deframer_crc32 #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_body_byte,
    output logic        o_has_byte,
    output logic        o_partial,
    output logic [31:0] o_keep_length
);

    localparam int IN_W  = $bits(lrd_pkg::t_in_item);
    localparam int OUT_W = $bits(lrd_pkg::t_out_item);

    lrd_pkg::t_in_item  w_in_beat;
    lrd_pkg::t_in_item  w_item;
    lrd_pkg::t_out_item w_res;
    lrd_pkg::t_out_item w_out;
    logic [IN_W-1:0]    w_item_bits;
    logic [OUT_W-1:0]   w_out_bits;
    logic               w_item_valid;
    logic               w_item_ready;
    logic               w_res_valid;
    logic               w_res_ready;

    assign w_in_beat.data_byte     = i_data_byte;
    assign w_in_beat.end_of_stream = i_end_of_stream;

    lrd_pipe_reg #(
        .WIDTH (IN_W)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (w_in_beat),
        .o_valid (w_item_valid),
        .i_ready (w_item_ready),
        .o_data  (w_item_bits)
    );

    assign w_item = lrd_pkg::t_in_item'(w_item_bits);

    lrd_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    lrd_pipe_reg #(
        .WIDTH (OUT_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out_bits)
    );

    assign w_out         = lrd_pkg::t_out_item'(w_out_bits);
    assign o_kind        = w_out.kind;
    assign o_body_byte   = w_out.body_byte;
    assign o_has_byte    = w_out.has_byte;
    assign o_partial     = w_out.partial;
    assign o_keep_length = w_out.keep_length;

    `LRD_ASSERT_SAME(a_end_always_reports, i_clk, i_rst_n, w_item_valid && w_item.end_of_stream, w_res_valid)
    `LRD_ASSERT_SAME(a_end_kind_matches, i_clk, i_rst_n, w_res_valid, (w_res.kind == lrd_pkg::KIND_END) == w_item.end_of_stream)
    `LRD_ASSERT_SAME(a_report_fields_clear, i_clk, i_rst_n, o_valid && (o_kind != lrd_pkg::KIND_END), !o_partial && (o_keep_length == 32'd0))
    `LRD_ASSERT_NEXT(a_out_holds_stalled, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(w_out_bits))

endmodule

// ===== tb/log_record_deframer_crc32_checker.sv =====
// ----------------------------------------------------------------------------
// Log record deframer checker
// Watches both channels of the deframer. It parses every accepted input beat
// with its own record parser and CRC-32, queues the results that the beat must
// cause, and compares each accepted output beat field by field with the oldest
// queued result.
// ----------------------------------------------------------------------------
module log_record_deframer_crc32_checker
    import lrd_pkg::*;
#(
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data_byte,
    input  logic        i_in_end_of_stream,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_out_kind,
    input  logic [7:0]  i_out_body_byte,
    input  logic        i_out_has_byte,
    input  logic        i_out_partial,
    input  logic [31:0] i_out_keep_length,
    output int          o_mismatch_count,
    output int          o_pending
);

    t_phase                 parse_phase;
    logic [1:0]             hdr_pos;
    logic [31:0]            body_left;
    logic [31:0]            crc_expected;
    logic [31:0]            crc_running;
    logic [OFFSET_BITS-1:0] bytes_seen;
    logic [OFFSET_BITS-1:0] keep_offset;
    logic                   stopped;

    t_out_item deframed_q[$];
    t_out_item oldest;
    int        mismatch_total = 0;

    assign o_mismatch_count = mismatch_total;

    function automatic logic [31:0] crc32_update_byte(input logic [31:0] crc,
                                                      input logic [7:0]  b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    task automatic clear_parser();
        parse_phase  = PH_LEN;
        hdr_pos      = 2'd0;
        body_left    = '0;
        crc_expected = '0;
        crc_running  = CRC_INIT;
        bytes_seen   = '0;
        keep_offset  = '0;
        stopped      = 1'b0;
    endtask

    task automatic queue_result(input t_kind k, input logic [7:0] b, input logic has,
                                input logic part, input logic [31:0] keep);
        t_out_item r;
        r.kind        = k;
        r.body_byte   = b;
        r.has_byte    = has;
        r.partial     = part;
        r.keep_length = keep;
        deframed_q.push_back(r);
    endtask

    // Closes the current record and queues its verdict.
    task automatic close_record(input logic [7:0] b, input logic has);
        logic [31:0] final_crc;
        final_crc   = ~crc_running;
        parse_phase = PH_LEN;
        hdr_pos     = 2'd0;
        body_left   = '0;
        crc_running = CRC_INIT;
        if (final_crc == crc_expected) begin
            keep_offset  = bytes_seen;
            crc_expected = '0;
            queue_result(KIND_ACCEPT, b, has, 1'b0, '0);
        end else begin
            stopped = 1'b1;
            queue_result(KIND_REJECT, b, has, 1'b0, '0);
        end
    endtask

    task automatic deframe_beat(input logic [7:0] b, input logic eos);
        logic part;
        if (eos) begin
            part = !stopped && (parse_phase != PH_LEN || hdr_pos != 2'd0);
            queue_result(KIND_END, 8'd0, 1'b0, part, 32'(keep_offset));
            clear_parser();
        end else if (!stopped) begin
            bytes_seen = bytes_seen + 1'b1;
            case (parse_phase)
                PH_CRC: begin
                    crc_expected[hdr_pos*8 +: 8] = b;
                    hdr_pos = hdr_pos + 2'd1;
                    if (hdr_pos == 2'd0) begin
                        if (body_left == 0) begin
                            close_record(8'd0, 1'b0);
                        end else begin
                            parse_phase = PH_BODY;
                            crc_running = CRC_INIT;
                        end
                    end
                end
                PH_BODY: begin
                    crc_running = crc32_update_byte(crc_running, b);
                    body_left   = body_left - 1;
                    if (body_left == 0) begin
                        close_record(b, 1'b1);
                    end else begin
                        queue_result(KIND_BODY, b, 1'b1, 1'b0, '0);
                    end
                end
                default: begin
                    parse_phase = PH_LEN;
                    body_left[hdr_pos*8 +: 8] = b;
                    hdr_pos = hdr_pos + 2'd1;
                    if (hdr_pos == 2'd0) begin
                        parse_phase  = PH_CRC;
                        crc_expected = '0;
                    end
                end
            endcase
        end
    endtask

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            deframed_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (deframed_q.size() == 0) begin
                    report_error($sformatf("unexpected result beat of kind %0d", i_out_kind));
                end else begin
                    oldest = deframed_q.pop_front();
                    check_field("kind", 32'(i_out_kind), 32'(oldest.kind));
                    check_field("body_byte", 32'(i_out_body_byte), 32'(oldest.body_byte));
                    check_field("has_byte", 32'(i_out_has_byte), 32'(oldest.has_byte));
                    check_field("partial", 32'(i_out_partial), 32'(oldest.partial));
                    check_field("keep_length", i_out_keep_length, oldest.keep_length);
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_beat(i_in_data_byte, i_in_end_of_stream);
            end
            o_pending <= deframed_q.size();
        end
    end

endmodule

// ===== tb/tb_log_record_deframer_crc32.sv =====
// ----------------------------------------------------------------------------
// Log record deframer testbench
// Feeds framed log records into the deframer: a few directed streams, then
// random streams of good, corrupted, truncated, empty and oversized records.
// Both sides idle at random, the receiver holds off once for a long stretch,
// and a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_log_record_deframer_crc32;
    import lrd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 400;
    localparam int HOLD_CYCLES  = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_data_byte;
    logic        in_end_of_stream;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_body_byte;
    logic        out_has_byte;
    logic        out_partial;
    logic [31:0] out_keep_length;

    int mismatch_count;
    int pending;
    int sent_beats = 0;
    int cycle_cnt  = 0;
    int hold_left  = 0;
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;

    logic [7:0] rec_body[$];
    logic [7:0] rec_frame[$];

    log_record_deframer_crc32 dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_data_byte     (in_data_byte),
        .i_end_of_stream (in_end_of_stream),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_kind          (out_kind),
        .o_body_byte     (out_body_byte),
        .o_has_byte      (out_has_byte),
        .o_partial       (out_partial),
        .o_keep_length   (out_keep_length)
    );

    log_record_deframer_crc32_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_in_data_byte     (in_data_byte),
        .i_in_end_of_stream (in_end_of_stream),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_out_kind         (out_kind),
        .i_out_body_byte    (out_body_byte),
        .i_out_has_byte     (out_has_byte),
        .i_out_partial      (out_partial),
        .i_out_keep_length  (out_keep_length),
        .o_mismatch_count   (mismatch_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = ~clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_beat(input logic [7:0] b, input logic eos);
        if (!calm) begin
            while ($urandom_range(0, 99) < 16) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid         <= 1'b1;
        in_data_byte     <= b;
        in_end_of_stream <= eos;
        do begin
            @(posedge clk);
        end while (!in_ready);
        @(negedge clk);
        sent_beats++;
    endtask

    task automatic fill_body(input int len);
        rec_body.delete();
        repeat (len) rec_body.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_frame(input bit corrupt);
        logic [31:0] len;
        logic [31:0] crc;
        crc = CRC_INIT;
        foreach (rec_body[i]) crc = crc_byte(crc, rec_body[i]);
        crc = ~crc;
        if (corrupt) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        len = rec_body.size();
        rec_frame.delete();
        for (int i = 0; i < 4; i++) rec_frame.push_back(len[8*i +: 8]);
        for (int i = 0; i < 4; i++) rec_frame.push_back(crc[8*i +: 8]);
        foreach (rec_body[i]) rec_frame.push_back(rec_body[i]);
    endtask

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++) push_beat(rec_frame[i], 1'b0);
    endtask

    task automatic end_stream();
        push_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic random_stream();
        int          n_rec;
        int          sel;
        int          len;
        int          n_junk;
        bit          done;
        logic [31:0] huge;
        n_rec = $urandom_range(1, 4);
        done  = 1'b0;
        for (int r = 0; r < n_rec && !done; r++) begin
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 60);
            if (sel < 68) begin
                fill_body(len);
                build_frame(1'b0);
                send_frame(rec_frame.size());
            end else if (sel < 78) begin
                fill_body(len);
                build_frame(1'b1);
                send_frame(rec_frame.size());
                n_junk = $urandom_range(0, 6);
                repeat (n_junk) push_beat(8'($urandom_range(0, 255)), 1'b0);
                sent_beats -= n_junk;
                done = 1'b1;
            end else if (sel < 88) begin
                fill_body(len);
                build_frame(1'b0);
                send_frame($urandom_range(1, rec_frame.size() - 1));
                done = 1'b1;
            end else if (sel < 93) begin
                huge = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h0100_0000);
                rec_body.delete();
                build_frame(1'b0);
                for (int i = 0; i < 4; i++) rec_frame[i] = huge[8*i +: 8];
                for (int i = 4; i < 8; i++) rec_frame[i] = 8'($urandom_range(0, 255));
                send_frame(8);
                repeat ($urandom_range(0, 20)) push_beat(8'($urandom_range(0, 255)), 1'b0);
                done = 1'b1;
            end else begin
                rec_body.delete();
                build_frame(bit'($urandom_range(0, 1)));
                send_frame(8);
                done = (rec_frame[4] | rec_frame[5] | rec_frame[6] | rec_frame[7]) != 8'd0;
            end
        end
        end_stream();
    endtask

    initial begin
        bit held;
        bit paused;
        held             = 1'b0;
        paused           = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_data_byte     = 8'd0;
        in_end_of_stream = 1'b0;
        out_ready        = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // An end beat on an empty stream, an empty record, a record holding the
        // byte extremes, then the largest length cut off before its CRC field.
        push_beat(8'hFF, 1'b1);
        rec_body.delete();
        build_frame(1'b0);
        send_frame(8);
        rec_body = '{8'h00, 8'hFF};
        build_frame(1'b0);
        send_frame(10);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b1);

        sent_beats = 0;
        while (sent_beats < RANDOM_BEATS) begin
            if (!held && sent_beats >= 120) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            calm = (sent_beats >= 180 && sent_beats < 260);
            if (!paused && sent_beats >= 300) begin
                paused = 1'b1;
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            random_stream();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
